FILE: hw/rtl/udpq_pkg.sv
// udpq_pkg: shared types and constants of the udp port demux with receive queues
// request, result and queue record structs, action and status codes
// no dependencies
`timescale 1ns / 1ps

package udpq_pkg;

  typedef enum logic [1:0] {
    ACT_BIND    = 2'd0,
    ACT_UNBIND  = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_RECEIVE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_IN_USE     = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_BOUND  = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_FULL       = 3'd5,
    ST_MALFORMED  = 3'd6,
    ST_IGNORED    = 3'd7
  } status_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  // ethernet + ip header, and ethernet + ip + udp header, in bytes
  localparam logic [16:0] ETH_IP_HDR     = 17'd34;
  localparam logic [15:0] ETH_IP_UDP_HDR = 16'd42;
  localparam logic [15:0] UDP_HDR        = 16'd8;

  typedef struct packed {
    action_t     action;
    logic [15:0] port;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_length;
    logic [15:0] frame_length;
    logic [15:0] max_len;
    logic [15:0] buffer_handle;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] xfer_len;
    logic [31:0] out_source_ip;
    logic [15:0] out_source_port;
    logic [15:0] out_handle;
    logic        handle_valid;
    logic        last;
  } out_rsp_t;

  // one queued packet record
  typedef struct packed {
    logic [15:0] length;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] handle;
  } rec_t;

endpackage

FILE: hw/rtl/udpq_rec_store.sv
// udpq_rec_store: record memory for all receive queues, one write and one read port
// read data is registered; depends on udpq_pkg (rec_t)
`timescale 1ns / 1ps

module udpq_rec_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  udpq_pkg::rec_t   wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output udpq_pkg::rec_t   rd_data
);
  import udpq_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/udp_port_demux_queues_top.sv
// udp_port_demux_queues_top: udp port table with per-port receive queues
// depends on udpq_pkg and udpq_rec_store
`timescale 1ns / 1ps

// channel  | ports                 | handshake
// ---------+-----------------------+----------------------------------------------
// request  | start, busy, in_req   | taken at a rising edge with start high, busy low
// result   | out_valid, out_rsp    | one-cycle out_valid strobe per result, no stall
//
// sequence: a request first scans the port table, one slot per cycle through a single
//   port comparator; the scan stops at the first bound match, else runs all NUM_PORTS
//   slots. a decide state (S_EXEC) follows; receive reads the record memory and adds an
//   output state (S_ROUT), unbind a read state (S_DRD) and an output state (S_DOUT) per
//   released handle.
// reset: synchronous active-low; clears the slot used flags and the sequencer, the
//   record memory is not cleared and needs no clearing pass.
// stalls: the receiver cannot hold results off; busy stays high until the last
//   result of a request has been registered.

module udp_port_demux_queues_top #(
  parameter int NUM_PORTS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  udpq_pkg::in_req_t  in_req,
  output logic               out_valid,
  output udpq_pkg::out_rsp_t out_rsp
);
  import udpq_pkg::*;

  localparam int SW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int REC = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW  = (REC > 1) ? $clog2(REC) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DRD,
    S_DOUT,
    S_ROUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // port table
  logic [NUM_PORTS-1:0] slot_used_r;
  logic [15:0]          slot_port_r   [NUM_PORTS];
  logic [QW-1:0]        queue_head_r  [NUM_PORTS];
  logic [QW-1:0]        queue_tail_r  [NUM_PORTS];
  logic [CW-1:0]        queue_count_r [NUM_PORTS];

  // request context
  in_req_t       req_r;
  logic [SW-1:0] idx_r;
  logic          found_r;
  logic          free_found_r;
  logic [SW-1:0] free_slot_r;
  logic [QW-1:0] ptr_r;
  logic [CW-1:0] rem_r;

  logic     out_valid_r;
  logic     out_valid_nxt;
  out_rsp_t out_rsp_r;
  out_rsp_t out_rsp_nxt;
  status_t  exec_st;

  // record memory port
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  rec_t          mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  rec_t          mem_rd_data;

  // current slot view, all at idx_r
  logic          cur_used;
  logic          cur_match;
  logic [QW-1:0] cur_head;
  logic [QW-1:0] cur_tail;
  logic [CW-1:0] cur_count;
  logic          q_full;
  logic          q_empty;

  // deliver frame checks, and the enqueue, dequeue and unbind drain conditions
  logic dlv_ignored;
  logic dlv_short;
  logic dlv_ulen_bad;
  logic dlv_over;
  logic dlv_enq;
  logic rcv_deq;
  logic unb_drain;

  logic [15:0] rcv_len;

  function automatic logic [QW-1:0] q_next(input logic [QW-1:0] v);
    return (v == QW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [AW-1:0] rec_addr(input logic [SW-1:0] s,
                                             input logic [QW-1:0] q);
    logic [AW:0] a;
    a = (AW+1)'(s) * (AW+1)'(QUEUE_DEPTH) + (AW+1)'(q);
    return a[AW-1:0];
  endfunction

  assign cur_used  = slot_used_r[idx_r];
  assign cur_match = cur_used && (slot_port_r[idx_r] == req_r.port);
  assign cur_head  = queue_head_r[idx_r];
  assign cur_tail  = queue_tail_r[idx_r];
  assign cur_count = queue_count_r[idx_r];
  assign q_full    = (cur_count >= CW'(QUEUE_DEPTH));
  assign q_empty   = (cur_count == '0);

  assign dlv_ignored  = (req_r.ether_type != ETHERTYPE_IPV4) ||
                        ({1'b0, req_r.frame_length} < ETH_IP_HDR) ||
                        (req_r.ip_protocol != PROTO_UDP);
  assign dlv_short    = (req_r.frame_length < ETH_IP_UDP_HDR);
  assign dlv_ulen_bad = (req_r.udp_length <= UDP_HDR);
  // 42 + (udp_length - 8) past the frame end
  assign dlv_over     = ({1'b0, req_r.udp_length} + ETH_IP_HDR) >
                        {1'b0, req_r.frame_length};

  assign dlv_enq = (state_r == S_EXEC) && (req_r.action == ACT_DELIVER) &&
                   !dlv_ignored && !dlv_short && found_r && !q_full &&
                   !dlv_ulen_bad && !dlv_over;
  assign rcv_deq = (state_r == S_EXEC) && (req_r.action == ACT_RECEIVE) &&
                   found_r && !q_empty;
  // unbind of a port with queued records goes on to hand them back
  assign unb_drain = (state_r == S_EXEC) && (req_r.action == ACT_UNBIND) &&
                     found_r && !q_empty;

  assign mem_wr_en          = dlv_enq;
  assign mem_wr_addr        = rec_addr(idx_r, cur_tail);
  assign mem_wr_data.length      = req_r.udp_length - UDP_HDR;
  assign mem_wr_data.source_ip   = req_r.source_ip;
  assign mem_wr_data.source_port = req_r.source_port;
  assign mem_wr_data.handle      = req_r.buffer_handle;

  assign mem_rd_en   = rcv_deq || (state_r == S_DRD);
  assign mem_rd_addr = rec_addr(idx_r, (state_r == S_DRD) ? ptr_r : cur_head);

  assign rcv_len = (req_r.max_len < mem_rd_data.length) ? req_r.max_len
                                                        : mem_rd_data.length;

  udpq_rec_store #(
    .DEPTH (REC),
    .AW    (AW)
  ) u_rec_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // status of the decide cycle
  always_comb begin
    exec_st = ST_OK;
    case (req_r.action)
      ACT_BIND: begin
        if (found_r) begin
          exec_st = ST_IN_USE;
        end else if (!free_found_r) begin
          exec_st = ST_TABLE_FULL;
        end
      end
      ACT_UNBIND: begin
        if (!found_r) begin
          exec_st = ST_NOT_BOUND;
        end
      end
      ACT_DELIVER: begin
        if (dlv_ignored) begin
          exec_st = ST_IGNORED;
        end else if (dlv_short) begin
          exec_st = ST_MALFORMED;
        end else if (!found_r) begin
          exec_st = ST_NOT_BOUND;
        end else if (q_full) begin
          exec_st = ST_FULL;
        end else if (dlv_ulen_bad || dlv_over) begin
          exec_st = ST_MALFORMED;
        end
      end
      ACT_RECEIVE: begin
        if (!found_r) begin
          exec_st = ST_NOT_BOUND;
        end else if (q_empty) begin
          exec_st = ST_EMPTY;
        end
      end
      default: begin
        exec_st = ST_OK;
      end
    endcase
  end

  // next state, result strobe and result payload
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cur_match || (idx_r == SW'(NUM_PORTS - 1))) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_rsp_nxt = '{status: exec_st, xfer_len: '0, out_source_ip: '0,
                        out_source_port: '0, out_handle: '0,
                        handle_valid: 1'b0, last: 1'b1};
        if (unb_drain) begin
          state_nxt = S_DRD;
        end else if (rcv_deq) begin
          // record read issued this cycle
          state_nxt = S_ROUT;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_DRD: begin
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: ST_OK, xfer_len: '0, out_source_ip: '0,
                          out_source_port: '0, out_handle: mem_rd_data.handle,
                          handle_valid: 1'b1, last: (rem_r == '0)};
        state_nxt     = (rem_r == '0) ? S_IDLE : S_DRD;
      end
      S_ROUT: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: ST_OK, xfer_len: rcv_len,
                          out_source_ip: mem_rd_data.source_ip,
                          out_source_port: mem_rd_data.source_port,
                          out_handle: mem_rd_data.handle,
                          handle_valid: 1'b1, last: 1'b1};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer, port table and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_rsp_r   <= out_rsp_nxt;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r        <= in_req;
            idx_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
          end
        end

        // one slot per cycle through the port comparator
        S_SCAN: begin
          if (cur_match) begin
            found_r <= 1'b1;
          end else begin
            if (!cur_used && !free_found_r) begin
              free_found_r <= 1'b1;
              free_slot_r  <= idx_r;
            end
            if (idx_r == SW'(NUM_PORTS - 1)) begin
              // no match: a bind goes on with the lowest free slot
              if (free_found_r) begin
                idx_r <= free_slot_r;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end

        S_EXEC: begin
          case (req_r.action)
            ACT_BIND: begin
              if (!found_r && free_found_r) begin
                slot_used_r[idx_r]   <= 1'b1;
                slot_port_r[idx_r]   <= req_r.port;
                queue_head_r[idx_r]  <= '0;
                queue_tail_r[idx_r]  <= '0;
                queue_count_r[idx_r] <= '0;
              end
            end
            ACT_UNBIND: begin
              if (found_r) begin
                slot_used_r[idx_r]   <= 1'b0;
                queue_head_r[idx_r]  <= '0;
                queue_tail_r[idx_r]  <= '0;
                queue_count_r[idx_r] <= '0;
              end
              if (unb_drain) begin
                // hand back every queued handle in queue order
                ptr_r <= cur_head;
                rem_r <= cur_count;
              end
            end
            ACT_DELIVER: begin
              if (dlv_enq) begin
                queue_tail_r[idx_r]  <= q_next(cur_tail);
                queue_count_r[idx_r] <= cur_count + 1'b1;
              end
            end
            ACT_RECEIVE: begin
              if (rcv_deq) begin
                queue_head_r[idx_r]  <= q_next(cur_head);
                queue_count_r[idx_r] <= cur_count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end

        S_DRD: begin
          ptr_r <= q_next(ptr_r);
          rem_r <= rem_r - 1'b1;
        end

        default: begin
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // a result that is not the last one leaves the block busy
  a_more_results_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |-> busy)
    else $error("non-final result while idle");

  // once idle, the result just shown closes its request
  a_idle_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_rsp.last)
    else $error("idle with a result not marked last");

  // an accepted request never yields a result on the next cycle (scan comes first)
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result right after accept");

  // handles only travel with an ok status
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.handle_valid |-> out_rsp.status == ST_OK)
    else $error("handle with error status");

  // the record memory is never written and read in the same cycle
  a_mem_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("record memory write and read together");

endmodule
